// ===== hdl/height_texture_bilinear_sampler_unit_defines.svh =====
// assertion macros used by the checker file hbs_chk.sv
`ifndef HEIGHT_TEXTURE_BILINEAR_SAMPLER_UNIT_DEFINES_SVH
`define HEIGHT_TEXTURE_BILINEAR_SAMPLER_UNIT_DEFINES_SVH

// same-cycle implication
`define HBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hbs_pkg.sv =====
package hbs_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int STORE_AW    = 16;
    localparam int TEXEL_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_DIM_W   = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd2;

    localparam logic [1:0] FMT_GRAY8  = 2'd0;
    localparam logic [1:0] FMT_GRAY16 = 2'd1;
    localparam logic [1:0] FMT_BGRA8  = 2'd2;
    localparam logic [1:0] FMT_HALF   = 2'd3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [15:0]        texel_index;
        logic [15:0]        raw_texel;
        logic signed [23:0] u_coord;
        logic signed [23:0] v_coord;
    } t_in_item;

    typedef struct packed {
        logic [15:0] height;
        logic        dims_valid;
    } t_out_item;

    typedef enum logic [1:0] {
        TAP_00,
        TAP_01,
        TAP_10,
        TAP_11
    } t_tap;

    typedef enum logic [1:0] {
        LERP_TOP,
        LERP_BOT,
        LERP_FIN
    } t_lerp_sel;

    typedef struct packed {
        logic      load_in;
        logic      wr_en;
        logic      coord_en;
        logic      index_en;
        logic      row_en;
        t_tap      tap;
        logic      cap_en;
        t_tap      cap_sel;
        logic      lerp_en;
        t_lerp_sel lerp_sel;
        logic      out_load;
        logic      out_zero;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic dims_ok;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/hbs_ram.sv =====
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/hbs_ctrl.sv =====
module hbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hbs_pkg::t_stat i_stat,
    output hbs_pkg::t_cmd  o_cmd
);

    import hbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_INDEX,
        S_ROW,
        S_F0,
        S_F1,
        S_F2,
        S_F3,
        S_F4,
        S_BOT,
        S_FIN,
        S_ZERO
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_FIRST;
                end
            end
            S_FIRST: begin
                if (i_stat.op == OP_WRITE) begin
                    cmd.wr_en = 1'b1;
                    n_state   = S_IDLE;
                end else if (!i_stat.dims_ok) begin
                    n_state = S_ZERO;
                end else begin
                    cmd.coord_en = 1'b1;
                    n_state      = S_INDEX;
                end
            end
            S_INDEX: begin
                cmd.index_en = 1'b1;
                n_state      = S_ROW;
            end
            S_ROW: begin
                cmd.row_en = 1'b1;
                n_state    = S_F0;
            end
            S_F0: begin
                cmd.tap = TAP_00;
                n_state = S_F1;
            end
            S_F1: begin
                cmd.tap     = TAP_01;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = TAP_00;
                n_state     = S_F2;
            end
            S_F2: begin
                cmd.tap     = TAP_10;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = TAP_01;
                n_state     = S_F3;
            end
            S_F3: begin
                cmd.tap      = TAP_11;
                cmd.cap_en   = 1'b1;
                cmd.cap_sel  = TAP_10;
                cmd.lerp_en  = 1'b1;
                cmd.lerp_sel = LERP_TOP;
                n_state      = S_F4;
            end
            S_F4: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = TAP_11;
                n_state     = S_BOT;
            end
            S_BOT: begin
                cmd.lerp_en  = 1'b1;
                cmd.lerp_sel = LERP_BOT;
                n_state      = S_FIN;
            end
            S_FIN: begin
                cmd.lerp_sel = LERP_FIN;
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_ZERO: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_zero = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== hdl/hbs_dp.sv =====
module hbs_dp #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  hbs_pkg::t_in_item                i_in,
    input  hbs_pkg::t_cmd                    i_cmd,
    output hbs_pkg::t_stat                   o_stat,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output hbs_pkg::t_out_item               o_out
);

    import hbs_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = (WW > CFG_DIM_W) ? WW : CFG_DIM_W;
    localparam int HCW = (HW > CFG_DIM_W) ? HW : CFG_DIM_W;
    localparam int PW  = WW + HW;
    localparam int AW  = (PW + 1 > STORE_AW) ? PW + 1 : STORE_AW;
    localparam int AXW = 16 + WW;
    localparam int FYW = 17 + HW;

    function automatic logic [15:0] f_half_q16(input logic [15:0] hb);
        logic [4:0]  expo;
        logic [9:0]  mant;
        logic [10:0] sig;
        logic [4:0]  sh;
        logic [26:0] prod;
        logic [27:0] sum;
        expo = hb[14:10];
        mant = hb[9:0];
        if (expo == 5'h1F && mant != 10'd0) begin
            return 16'hFFFF;
        end
        if (hb[15]) begin
            return 16'h0000;
        end
        if (expo >= 5'd15) begin
            return 16'hFFFF;
        end
        if (expo == 5'd0) begin
            sig = {1'b0, mant};
            sh  = 5'd24;
        end else begin
            sig = {1'b1, mant};
            sh  = 5'd25 - expo;
        end
        prod = {sig, 16'h0000} - 27'(sig);
        sum  = 28'(prod) + (28'd1 << (sh - 5'd1));
        return 16'(sum >> sh);
    endfunction

    // configuration
    logic [CFG_DIM_W-1:0] r_width;
    logic [CFG_DIM_W-1:0] r_height;
    logic [1:0]           r_format;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_format <= FMT_GRAY8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_FORMAT: r_format <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic [WCW-1:0] w_cfg;
    logic [HCW-1:0] h_cfg;
    logic [WW-1:0]  w;
    logic [HW-1:0]  h;
    logic [HW-1:0]  hm1;

    assign w_cfg = WCW'(r_width);
    assign h_cfg = HCW'(r_height);
    assign w     = (w_cfg > WCW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_cfg);
    assign h     = (h_cfg > HCW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(h_cfg);
    assign hm1   = h - HW'(1);

    // request register
    t_in_item r_in;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in;
        end
    end

    // texel normalization
    logic [15:0] norm;

    always_comb begin
        case (r_format)
            FMT_GRAY8:  norm = {r_in.raw_texel[7:0], r_in.raw_texel[7:0]};
            FMT_GRAY16: norm = r_in.raw_texel;
            FMT_BGRA8:  norm = {r_in.raw_texel[7:0], r_in.raw_texel[7:0]};
            FMT_HALF:   norm = f_half_q16(r_in.raw_texel);
            default:    norm = r_in.raw_texel;
        endcase
    end

    // coordinate scaling
    logic [16:0]    vc;
    logic [AXW-1:0] r_a;
    logic [FYW-1:0] r_fy;

    always_comb begin
        if (r_in.v_coord[23]) begin
            vc = '0;
        end else if (r_in.v_coord > 24'sd65536) begin
            vc = 17'h10000;
        end else begin
            vc = r_in.v_coord[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coord_en) begin
            r_a  <= AXW'(r_in.u_coord[15:0]) * AXW'(w);
            r_fy <= FYW'(vc) * FYW'(hm1);
        end
    end

    // texel indices and weights
    logic           a_ge;
    logic [AXW-1:0] t_sub;
    logic [WW-1:0]  x0_n;
    logic [WW-1:0]  x1_n;
    logic [WW:0]    x0p1;
    logic [15:0]    tx_n;
    logic [HW:0]    y0f;
    logic [HW-1:0]  y0_n;
    logic [HW:0]    y1p;
    logic [HW-1:0]  y1_n;

    assign a_ge  = (r_a >= AXW'(32768));
    assign t_sub = r_a - AXW'(32768);
    assign x0_n  = a_ge ? t_sub[AXW-1:16] : (w - WW'(1));
    assign tx_n  = a_ge ? t_sub[15:0] : {1'b1, r_a[14:0]};
    assign x0p1  = {1'b0, x0_n} + (WW+1)'(1);
    assign x1_n  = (x0p1 >= {1'b0, w}) ? '0 : x0p1[WW-1:0];
    assign y0f   = r_fy[FYW-1:16];
    assign y0_n  = (y0f > {1'b0, hm1}) ? hm1 : y0f[HW-1:0];
    assign y1p   = {1'b0, y0_n} + (HW+1)'(1);
    assign y1_n  = (y1p > {1'b0, hm1}) ? hm1 : y1p[HW-1:0];

    logic [WW-1:0] r_x0;
    logic [WW-1:0] r_x1;
    logic [HW-1:0] r_y0;
    logic [HW-1:0] r_y1;
    logic [15:0]   r_tx;
    logic [15:0]   r_ty;

    always_ff @(posedge i_clk) begin
        if (i_cmd.index_en) begin
            r_x0 <= x0_n;
            r_x1 <= x1_n;
            r_y0 <= y0_n;
            r_y1 <= y1_n;
            r_tx <= tx_n;
            r_ty <= r_fy[15:0];
        end
    end

    // row bases
    logic [PW-1:0] r_base0;
    logic [PW-1:0] r_base1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_en) begin
            r_base0 <= PW'(r_y0) * PW'(w);
            r_base1 <= PW'(r_y1) * PW'(w);
        end
    end

    // store access
    logic [PW-1:0]       base_sel;
    logic [WW-1:0]       x_sel;
    logic [AW-1:0]       addr_sum;
    logic [STORE_AW-1:0] ram_addr;
    logic [TEXEL_W-1:0]  ram_rdata;

    assign base_sel = (i_cmd.tap == TAP_10 || i_cmd.tap == TAP_11) ? r_base1 : r_base0;
    assign x_sel    = (i_cmd.tap == TAP_01 || i_cmd.tap == TAP_11) ? r_x1 : r_x0;
    assign addr_sum = AW'(base_sel) + AW'(x_sel);
    assign ram_addr = i_cmd.wr_en ? r_in.texel_index : addr_sum[STORE_AW-1:0];

    hbs_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_addr  (ram_addr),
        .i_wdata (norm),
        .o_rdata (ram_rdata)
    );

    logic [TEXEL_W-1:0] r_q [4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            r_q[i_cmd.cap_sel] <= ram_rdata;
        end
    end

    // shared lerp unit
    logic [15:0]        l_a;
    logic [15:0]        l_b;
    logic [15:0]        l_t;
    logic signed [16:0] l_diff;
    logic signed [33:0] l_prod;
    logic signed [17:0] l_sum;
    logic [15:0]        l_res;
    logic [15:0]        r_top;
    logic [15:0]        r_bot;

    always_comb begin
        case (i_cmd.lerp_sel)
            LERP_TOP: begin
                l_a = r_q[0];
                l_b = r_q[1];
                l_t = r_tx;
            end
            LERP_BOT: begin
                l_a = r_q[2];
                l_b = r_q[3];
                l_t = r_tx;
            end
            LERP_FIN: begin
                l_a = r_top;
                l_b = r_bot;
                l_t = r_ty;
            end
            default: begin
                l_a = r_top;
                l_b = r_bot;
                l_t = r_ty;
            end
        endcase
    end

    assign l_diff = $signed({1'b0, l_b}) - $signed({1'b0, l_a});
    assign l_prod = l_diff * $signed({1'b0, l_t});
    assign l_sum  = $signed({2'b00, l_a}) + $signed(l_prod[33:16]);
    assign l_res  = l_sum[15:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.lerp_en && i_cmd.lerp_sel == LERP_TOP) begin
            r_top <= l_res;
        end
        if (i_cmd.lerp_en && i_cmd.lerp_sel == LERP_BOT) begin
            r_bot <= l_res;
        end
    end

    // result register
    logic      r_out_valid;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.height     <= i_cmd.out_zero ? 16'h0000 : l_res;
            r_out.dims_valid <= !i_cmd.out_zero;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;
    assign o_stat.op       = r_in.op;
    assign o_stat.dims_ok  = (r_width != '0) && (r_height != '0);
    assign o_stat.out_free = !r_out_valid;

endmodule

// ===== hdl/height_texture_bilinear_sampler_unit.sv =====
// Bilinear height sampler over a 65536 x 16 texel store. A write request stores
// one normalized texel in the cycle after acceptance, and the next request is
// taken once that write is done. A sample request reads four texels one after
// another through the single store port and blends them with one shared lerp
// unit; no new request is taken until its result is loaded into the output
// register. A sample with a zero texture dimension gives a zero height. The last
// step of a sample holds for as long as the previous result still waits
// unaccepted in the output register. The store has no reset, so sampled texels
// must have been written first. Configuration takes effect at once; the user must
// write it only between requests, as the block does not enforce this.
module height_texture_bilinear_sampler_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  hbs_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output hbs_pkg::t_out_item             o_out
);

    import hbs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    hbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hbs_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== hdl/hbs_chk.sv =====
`include "height_texture_bilinear_sampler_unit_defines.svh"

module hbs_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input hbs_pkg::t_in_item   i_in,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input hbs_pkg::t_out_item  o_out
);

    import hbs_pkg::*;

    `HBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "result changed while stalled")
    `HBS_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "request taken while busy")
    `HBS_ASSERT_SAME(a_no_dims_zero, i_clk, i_rst_n, o_out_valid && !o_out.dims_valid, o_out.height == 16'h0000, "missing texture must give zero height")
    `HBS_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in.op == OP_WRITE && !o_out_valid, !o_out_valid, "write request produced a result")

endmodule

bind height_texture_bilinear_sampler_unit hbs_chk u_hbs_chk (.*);

// ===== dv/height_texture_bilinear_sampler_unit_test.sv =====
`timescale 1ns / 1ps

typedef struct packed {
    bit [15:0] addr_tl;
    bit [15:0] addr_tr;
    bit [15:0] addr_bl;
    bit [15:0] addr_br;
    bit [15:0] frac_x;
    bit [15:0] frac_y;
} t_footprint;

class height_sample_board #(int MAX_W = 256, int MAX_H = 256);
    bit [15:0]          texel_heights [0:65535];
    bit [8:0]           tex_width;
    bit [8:0]           tex_height;
    bit [1:0]           texel_format;
    hbs_pkg::t_out_item expected_heights [$];
    int unsigned        mismatches;

    function void set_reg(logic [1:0] index, logic [8:0] value);
        case (index)
            hbs_pkg::CFG_WIDTH: tex_width = value;
            hbs_pkg::CFG_HEIGHT: tex_height = value;
            hbs_pkg::CFG_FORMAT: texel_format = value[1:0];
            default: ;
        endcase
    endfunction

    function int unsigned cols();
        return (tex_width > MAX_W) ? MAX_W : tex_width;
    endfunction

    function int unsigned rows();
        return (tex_height > MAX_H) ? MAX_H : tex_height;
    endfunction

    function int unsigned pending();
        return expected_heights.size();
    endfunction

    function bit [15:0] half_to_height(bit [15:0] raw);
        bit [4:0]    expo;
        bit [9:0]    mant;
        bit [10:0]   sig;
        bit [63:0]   prod;
        int unsigned sh;
        expo = raw[14:10];
        mant = raw[9:0];
        if (expo == 5'h1F && mant != 0) return 16'hFFFF;
        if (raw[15]) return 16'h0000;
        if (expo >= 15) return 16'hFFFF;
        if (expo == 0) begin
            sig = {1'b0, mant};
            sh  = 24;
        end else begin
            sig = {1'b1, mant};
            sh  = 25 - expo;
        end
        prod = 64'(sig) * 64'd65535;
        return 16'((prod + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function bit [15:0] normalize(bit [15:0] raw);
        case (texel_format)
            hbs_pkg::FMT_GRAY16: return raw;
            hbs_pkg::FMT_HALF: return half_to_height(raw);
            default: return 16'(raw[7:0]) * 16'd257;
        endcase
    endfunction

    function bit [15:0] blend(bit [15:0] a, bit [15:0] b, bit [15:0] frac);
        bit [47:0] s;
        s = 48'(a) * (48'd65536 - 48'(frac)) + 48'(b) * 48'(frac);
        return s[31:16];
    endfunction

    // four taps and weights of a sample, only for nonzero dimensions
    function t_footprint locate(hbs_pkg::t_in_item req);
        t_footprint  fp;
        int unsigned w, h, a, x0, x1, y0, y1, fy;
        int          v;
        w = cols();
        h = rows();
        a = req.u_coord[15:0] * w;
        if (a >= 32768) begin
            x0 = (a - 32768) >> 16;
            fp.frac_x = 16'(a - 32768);
        end else begin
            x0 = w - 1;
            fp.frac_x = 16'(a + 32768);
        end
        x1 = (x0 + 1 >= w) ? 0 : x0 + 1;
        v = req.v_coord;
        if (v < 0) v = 0;
        else if (v > 65536) v = 65536;
        fy = v * (h - 1);
        y0 = fy >> 16;
        fp.frac_y = 16'(fy);
        if (y0 > h - 1) y0 = h - 1;
        y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
        fp.addr_tl = 16'(y0 * w + x0);
        fp.addr_tr = 16'(y0 * w + x1);
        fp.addr_bl = 16'(y1 * w + x0);
        fp.addr_br = 16'(y1 * w + x1);
        return fp;
    endfunction

    function void note_request(hbs_pkg::t_in_item req);
        hbs_pkg::t_out_item res;
        t_footprint         fp;
        bit [15:0]          top;
        bit [15:0]          bot;
        if (req.op == hbs_pkg::OP_WRITE) begin
            texel_heights[req.texel_index] = normalize(req.raw_texel);
            return;
        end
        res = '0;
        if (cols() != 0 && rows() != 0) begin
            fp  = locate(req);
            top = blend(texel_heights[fp.addr_tl], texel_heights[fp.addr_tr], fp.frac_x);
            bot = blend(texel_heights[fp.addr_bl], texel_heights[fp.addr_br], fp.frac_x);
            res.height     = blend(top, bot, fp.frac_y);
            res.dims_valid = 1'b1;
        end
        expected_heights.push_back(res);
    endfunction

    function void check_result(hbs_pkg::t_out_item got);
        hbs_pkg::t_out_item want;
        if (expected_heights.size() == 0) begin
            $error("unexpected result height=%0d dims_valid=%0d", got.height, got.dims_valid);
            mismatches++;
            return;
        end
        want = expected_heights.pop_front();
        if (got.height !== want.height) begin
            $error("height: expected %0d, actual %0d", want.height, got.height);
            mismatches++;
        end
        if (got.dims_valid !== want.dims_valid) begin
            $error("dims_valid: expected %0d, actual %0d", want.dims_valid, got.dims_valid);
            mismatches++;
        end
    endfunction
endclass

module height_texture_bilinear_sampler_unit_test;
    import hbs_pkg::*;

    localparam int MAX_WIDTH       = 256;
    localparam int MAX_HEIGHT      = 256;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int PHASE_ITEMS     = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef height_sample_board #(.MAX_W(MAX_WIDTH), .MAX_H(MAX_HEIGHT)) t_board;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out;

    t_board board = new();

    bit          texel_written [0:65535];
    int          send_idle_pct = 20;
    int          recv_idle_pct = 65;
    bit          hold_off_req  = 1'b0;
    int unsigned requests_sent = 0;
    int unsigned stall_count   = 0;

    height_texture_bilinear_sampler_unit #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out(o_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        int hold;
        hold = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) board.check_result(o_out);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = HOLD_OFF_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(index, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [8:0] w, logic [8:0] h, logic [1:0] fmt);
        drain();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_FORMAT, 9'(fmt));
    endtask

    task automatic send_request(t_in_item req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(req);
        if (req.op == OP_WRITE) texel_written[req.texel_index] = 1'b1;
        requests_sent++;
    endtask

    function automatic t_in_item make_write(logic [15:0] index, logic [15:0] raw);
        t_in_item req;
        req.op          = OP_WRITE;
        req.texel_index = index;
        req.raw_texel   = raw;
        req.u_coord     = 24'($urandom);
        req.v_coord     = 24'($urandom);
        return req;
    endfunction

    function automatic t_in_item make_sample(logic [23:0] u, logic [23:0] v);
        t_in_item req;
        req.op          = OP_SAMPLE;
        req.texel_index = 16'($urandom);
        req.raw_texel   = 16'($urandom);
        req.u_coord     = u;
        req.v_coord     = v;
        return req;
    endfunction

    function automatic logic [15:0] random_raw();
        if (board.texel_format == FMT_HALF && $urandom_range(0, 1) == 1)
            return 16'($urandom_range(0, 16'h3C00));
        return 16'($urandom);
    endfunction

    function automatic logic [23:0] random_u();
        logic [15:0] frac;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0: frac = 16'h0000;
                1: frac = 16'h7FFF;
                2: frac = 16'h8000;
                default: frac = 16'hFFFF;
            endcase
            return {8'($urandom), frac};
        end
        return 24'($urandom);
    endfunction

    function automatic logic [23:0] random_v();
        case ($urandom_range(0, 7))
            0: return 24'($urandom);
            1: return 24'hFFFFFF;
            2: return 24'h010000;
            3: return 24'h010001;
            4: return 24'h000000;
            default: return 24'($urandom_range(0, 65536));
        endcase
    endfunction

    // taps never written get a texel first, then the sample itself
    task automatic sample_with_taps(logic [23:0] u, logic [23:0] v);
        t_in_item   req;
        t_footprint fp;
        logic [15:0] taps [4];
        req = make_sample(u, v);
        if (board.cols() != 0 && board.rows() != 0) begin
            fp = board.locate(req);
            taps = '{fp.addr_tl, fp.addr_tr, fp.addr_bl, fp.addr_br};
            foreach (taps[k]) begin
                if (!texel_written[taps[k]]) send_request(make_write(taps[k], random_raw()));
            end
        end
        send_request(req);
    endtask

    task automatic directed_checks();
        configure(9'd2, 9'd2, FMT_HALF);
        write_reg(CFG_UNUSED, 9'h1FF);
        send_request(make_write(16'd0, 16'h8000));
        send_request(make_write(16'd1, 16'h7C00));
        send_request(make_write(16'd2, 16'h7E00));
        send_request(make_write(16'd3, 16'h3C00));
        send_request(make_sample(24'h000000, 24'h000000));
        send_request(make_write(16'd0, 16'h0001));
        send_request(make_write(16'd1, 16'h3800));
        send_request(make_write(16'd2, 16'h3BFF));
        send_request(make_write(16'd3, 16'hFC00));
        send_request(make_sample(24'h7FFFFF, 24'h7FFFFF));
        send_request(make_sample(24'h800000, 24'h800000));
        send_request(make_sample(24'h008000, 24'h008000));
        send_request(make_sample(24'hFFFFFF, 24'h010000));
        send_request(make_sample(24'h00C000, 24'h00FFFF));
        send_request(make_write(16'hFFFF, 16'hFFFF));
        send_request(make_write(16'd1, 16'h0000));
        send_request(make_write(16'd2, 16'h3555));
        send_request(make_sample(24'h004000, 24'h00C000));
    endtask

    task automatic run_phase(logic [8:0] w, logic [8:0] h, logic [1:0] fmt,
                             int send_idle, int recv_idle, bit pressure);
        int unsigned target;
        int unsigned halfway;
        int unsigned pick;
        bit          held;
        configure(w, h, fmt);
        send_idle_pct = send_idle;
        recv_idle_pct = recv_idle;
        target  = requests_sent + PHASE_ITEMS;
        halfway = requests_sent + PHASE_ITEMS / 2;
        held    = 1'b0;
        while (requests_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                sample_with_taps(random_u(), random_v());
                if (pressure && !held) begin
                    hold_off_req = 1'b1;
                    held = 1'b1;
                end
            end else if (pick < 80 && board.cols() != 0 && board.rows() != 0) begin
                send_request(make_write(
                    16'($urandom_range(0, board.cols() * board.rows() - 1)), random_raw()));
            end else begin
                send_request(make_write(16'($urandom), random_raw()));
            end
            if (pressure && requests_sent == halfway) drain();
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_checks();

        run_phase(9'd1,   9'd1,   FMT_GRAY8,  20, 65, 1'b0);
        run_phase(9'd256, 9'd256, FMT_GRAY16, 20, 65, 1'b1);
        run_phase(9'd511, 9'd300, FMT_BGRA8,  20, 65, 1'b0);
        run_phase(9'd0,   9'd5,   FMT_HALF,   65, 20, 1'b0);
        run_phase(9'd7,   9'd0,   FMT_GRAY8,  65, 20, 1'b0);
        run_phase(9'd3,   9'd200, FMT_HALF,   65, 20, 1'b0);
        run_phase(9'd256, 9'd1,   FMT_GRAY16, 0,  0,  1'b0);
        run_phase(9'd1,   9'd256, FMT_BGRA8,  0,  0,  1'b0);
        run_phase(9'd13,  9'd17,  FMT_HALF,   0,  0,  1'b0);
        run_phase(9'd100, 9'd60,  FMT_GRAY8,  0,  0,  1'b0);

        drain();
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
